### rtl/erd_pkg.sv
package erd_pkg;

  localparam logic [7:0] C_ESC = 8'h1B;
  localparam logic [7:0] C_SYN = 8'h16;
  localparam logic [7:0] C_ACK = 8'h06;
  localparam logic [7:0] C_BEL = 8'h07;
  localparam logic [7:0] C_NAK = 8'h15;

  localparam logic [7:0] ESC_DIG0 = 8'h30;
  localparam logic [7:0] ESC_DIG1 = 8'h31;
  localparam logic [7:0] ESC_DIG2 = 8'h32;
  localparam logic [7:0] ESC_DIG3 = 8'h33;
  localparam logic [7:0] ESC_DIG4 = 8'h34;

  localparam logic [1:0] HUNT_LIMIT = 2'd3;
  localparam logic [7:0] TICK_MAX   = 8'hFF;
  localparam logic [7:0] TIMEOUT_RESET = 8'd31;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_TICK = 2'd1,
    REQ_SENT = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADESC  = 3'd1,
    ST_TRUNC   = 3'd2,
    ST_NOLEAD  = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lead_code;
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    phase_e     phase;
    logic       escape_seen;
    logic [7:0] held_lead;
    logic [7:0] held_first;
    logic       corrupt_mark;
    logic [1:0] hunt_count;
    logic [7:0] tick_count;
  } dfr_state_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b == C_ACK) || (b == C_BEL) || (b == C_NAK);
  endfunction

endpackage

### rtl/erd_step.sv
module erd_step #(
  parameter int unsigned MaxPending = 15,
  parameter int unsigned PendW      = 4
) (
  input  erd_pkg::in_item_t   item_i,
  input  erd_pkg::dfr_state_t st_i,
  input  logic [PendW-1:0]    pend_i,
  input  logic [7:0]          timeout_i,
  output erd_pkg::dfr_state_t st_o,
  output logic [PendW-1:0]    pend_o,
  output logic                res_valid_o,
  output erd_pkg::out_item_t  res_o
);
  import erd_pkg::*;

  logic             hunting;
  logic [PendW-1:0] pend_dec;
  logic [PendW-1:0] pend_inc;
  logic [7:0]       tick_n;
  logic [1:0]       hunt_n;
  logic [7:0]       val;
  logic             bad_esc;
  logic [7:0]       b;

  dfr_state_t hunt_st;

  assign b        = item_i.rx_byte;
  assign hunting  = !(st_i.phase == PH_FIRST || st_i.phase == PH_SECOND);
  assign pend_dec = (pend_i != '0) ? pend_i - 1'b1 : pend_i;
  assign pend_inc = (pend_i != MaxPending[PendW-1:0]) ? pend_i + 1'b1 : pend_i;
  assign tick_n   = (st_i.tick_count != TICK_MAX) ? st_i.tick_count + 8'd1 : st_i.tick_count;
  assign hunt_n   = st_i.hunt_count + 2'd1;

  always_comb begin
    hunt_st              = st_i;
    hunt_st.phase        = PH_HUNT;
    hunt_st.escape_seen  = 1'b0;
    hunt_st.corrupt_mark = 1'b0;
    hunt_st.hunt_count   = '0;
    hunt_st.tick_count   = '0;
  end

  always_comb begin
    bad_esc = 1'b0;
    val     = b;
    if (st_i.escape_seen) begin
      case (b)
        ESC_DIG0: val = C_ESC;
        ESC_DIG1: val = C_SYN;
        ESC_DIG2: val = C_ACK;
        ESC_DIG3: val = C_BEL;
        ESC_DIG4: val = C_NAK;
        default:  bad_esc = 1'b1;
      endcase
    end
  end

  always_comb begin
    st_o        = st_i;
    pend_o      = pend_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (item_i.req_type)
      REQ_SENT: pend_o = pend_inc;
      REQ_TICK: begin
        if (!(hunting && pend_i == '0)) begin
          st_o.tick_count = tick_n;
          if (tick_n >= timeout_i) begin
            if (hunting) pend_o = pend_dec;
            st_o         = hunt_st;
            res_valid_o  = 1'b1;
            res_o.status = ST_TIMEOUT;
          end
        end
      end
      REQ_BYTE: begin
        if (hunting) begin
          if (pend_i != '0 && b != C_ESC) begin
            if (is_lead(b)) begin
              st_o            = hunt_st;
              st_o.phase      = PH_FIRST;
              st_o.held_lead  = b;
              st_o.held_first = '0;
              pend_o          = pend_dec;
            end else if (hunt_n >= HUNT_LIMIT) begin
              st_o         = hunt_st;
              pend_o       = pend_dec;
              res_valid_o  = 1'b1;
              res_o.status = ST_NOLEAD;
            end else begin
              st_o.hunt_count = hunt_n;
            end
          end
        end else if (is_lead(b)) begin
          st_o            = hunt_st;
          st_o.phase      = PH_FIRST;
          st_o.held_lead  = b;
          st_o.held_first = '0;
          pend_o          = pend_dec;
          res_valid_o     = 1'b1;
          res_o.status    = ST_TRUNC;
        end else if (!st_i.escape_seen && b == C_ESC) begin
          st_o.escape_seen = 1'b1;
        end else begin
          st_o.escape_seen  = 1'b0;
          st_o.corrupt_mark = st_i.corrupt_mark | bad_esc;
          if (st_i.phase == PH_FIRST) begin
            st_o.held_first = val;
            st_o.phase      = PH_SECOND;
          end else begin
            st_o        = hunt_st;
            res_valid_o = 1'b1;
            if (st_i.corrupt_mark || bad_esc) begin
              res_o.status = ST_BADESC;
            end else begin
              res_o.lead_code   = st_i.held_lead;
              res_o.data_first  = st_i.held_first;
              res_o.data_second = val;
              res_o.status      = ST_OK;
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/escaped_response_deframer_unit.sv
// Escaped response deframer: takes one item per cycle (received byte, time tick,
// or request-sent notice) and rebuilds three-byte replies (ACK/BEL/NAK lead plus
// two ESC-stuffed data bytes), giving at most one result item per input item.
// Each item passes the input register, then one pass of decode/state-update logic
// into the result register; that step waits while an earlier result is not taken. A new
// item is taken every cycle while results are taken. The user writes timeout_ticks
// through cfg_we_i/cfg_data_i only while the block is idle; it is not enforced.
module escaped_response_deframer_unit #(
  parameter int unsigned MAX_PENDING = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  erd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output erd_pkg::out_item_t out_item_o
);
  import erd_pkg::*;

  localparam int unsigned PEND_W = $clog2(MAX_PENDING + 1);

  logic             in_valid_q;
  in_item_t         in_item_q;
  logic             out_valid_q;
  out_item_t        out_item_q;
  logic [7:0]       timeout_q;
  dfr_state_t       st_q, st_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic             res_valid;
  out_item_t        res;
  logic             fire;

  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  erd_step #(
    .MaxPending (MAX_PENDING),
    .PendW      (PEND_W)
  ) u_step (
    .item_i      (in_item_q),
    .st_i        (st_q),
    .pend_i      (pend_q),
    .timeout_i   (timeout_q),
    .st_o        (st_d),
    .pend_o      (pend_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= TIMEOUT_RESET;
      st_q        <= '{phase: PH_HUNT, default: '0};
      pend_q      <= '0;
    end else begin
      if (cfg_we_i) timeout_q <= cfg_data_i;
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (fire) begin
        st_q        <= st_d;
        pend_q      <= pend_d;
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_item_q <= in_item_i;
    if (fire && res_valid) out_item_q <= res;
  end

endmodule

### verif/escaped_response_deframer_unit_tb.sv
`timescale 1ns / 100ps

module escaped_response_deframer_unit_tb;
  import erd_pkg::*;

  localparam int PEND_MAX    = 15;
  localparam int SETTLE      = 8;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 200;
  localparam int PRINT_CAP   = 100;

  typedef struct packed {
    in_item_t  item;
    logic      known;
    out_item_t res;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_item_o;

  // shared between sender and receiver (written with NBAs)
  int        rx_pct = 0;
  logic      hold_go = 1'b0;

  int        send_pct;
  int        errors = 0;
  int        items_in = 0;
  int        results_out = 0;
  int        st_seen [5];
  int        hold_left = 0;
  bit        hold_done = 0;
  int        stall_cycles = 0;
  int        mid_tmo = 0;

  out_item_t reply_q [$];
  in_item_t  stim_q [$];

  // predictor state
  phase_e     dph = PH_HUNT;
  logic       esc_pend = 1'b0;
  logic [7:0] lead_hold = '0;
  logic [7:0] first_hold = '0;
  logic       corrupt = 1'b0;
  int         hunt_n = 0;
  int         pend_n = 0;
  logic [7:0] tick_n = '0;
  logic [7:0] tmo = TIMEOUT_RESET;

  escaped_response_deframer_unit #(
    .MAX_PENDING(PEND_MAX)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic is_reply_lead(input logic [7:0] b);
    return (b == C_ACK) || (b == C_BEL) || (b == C_NAK);
  endfunction

  function automatic void drop_pending();
    if (pend_n > 0) pend_n--;
  endfunction

  function automatic void back_to_hunt();
    dph = PH_HUNT;
    esc_pend = 1'b0;
    corrupt = 1'b0;
    hunt_n = 0;
    tick_n = '0;
  endfunction

  function automatic void open_reply(input logic [7:0] b);
    lead_hold = b;
    first_hold = '0;
    drop_pending();
    back_to_hunt();
    dph = PH_FIRST;
  endfunction

  // advances the deframer state by one item; returns 1 when a reply comes out
  function automatic bit deframe_step(input in_item_t it, output out_item_t res);
    logic [7:0] b;
    logic [7:0] val;
    bit hunting;
    b = it.rx_byte;
    hunting = (dph != PH_FIRST) && (dph != PH_SECOND);
    res = '0;
    case (it.req_type)
      REQ_SENT: begin
        if (pend_n < PEND_MAX) pend_n++;
        return 0;
      end
      REQ_TICK: begin
        if (hunting && pend_n == 0) return 0;
        if (tick_n != TICK_MAX) tick_n = tick_n + 8'd1;
        if (tick_n < tmo) return 0;
        if (hunting) drop_pending();
        back_to_hunt();
        res.status = ST_TIMEOUT;
        return 1;
      end
      REQ_BYTE: begin
        if (hunting) begin
          if (pend_n == 0 || b == C_ESC) return 0;
          if (is_reply_lead(b)) begin
            open_reply(b);
            return 0;
          end
          hunt_n++;
          if (hunt_n >= int'(HUNT_LIMIT)) begin
            drop_pending();
            back_to_hunt();
            res.status = ST_NOLEAD;
            return 1;
          end
          return 0;
        end
        if (is_reply_lead(b)) begin
          open_reply(b);
          res.status = ST_TRUNC;
          return 1;
        end
        if (!esc_pend && b == C_ESC) begin
          esc_pend = 1'b1;
          return 0;
        end
        val = b;
        if (esc_pend) begin
          case (b)
            ESC_DIG0: val = C_ESC;
            ESC_DIG1: val = C_SYN;
            ESC_DIG2: val = C_ACK;
            ESC_DIG3: val = C_BEL;
            ESC_DIG4: val = C_NAK;
            default:  corrupt = 1'b1;
          endcase
          esc_pend = 1'b0;
        end
        if (dph == PH_FIRST) begin
          first_hold = val;
          dph = PH_SECOND;
          return 0;
        end
        if (corrupt) begin
          back_to_hunt();
          res.status = ST_BADESC;
          return 1;
        end
        res.lead_code = lead_hold;
        res.data_first = first_hold;
        res.data_second = val;
        res.status = ST_OK;
        back_to_hunt();
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic in_item_t item_of(input req_e r, input logic [7:0] b);
    in_item_t it;
    it.req_type = r;
    it.rx_byte = b;
    return it;
  endfunction

  function automatic dir_row_t dir_plain(input req_e r, input logic [7:0] b);
    dir_row_t d;
    d.item = item_of(r, b);
    d.known = 1'b0;
    d.res = '0;
    return d;
  endfunction

  function automatic dir_row_t dir_known(input req_e r, input logic [7:0] b,
                                         input logic [7:0] l, input logic [7:0] d1,
                                         input logic [7:0] d2, input status_e st);
    dir_row_t d;
    d.item = item_of(r, b);
    d.known = 1'b1;
    d.res.lead_code = l;
    d.res.data_first = d1;
    d.res.data_second = d2;
    d.res.status = st;
    return d;
  endfunction

  function automatic logic [7:0] pick_lead();
    case ($urandom_range(2))
      0:       return C_ACK;
      1:       return C_BEL;
      default: return C_NAK;
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == C_ESC || is_reply_lead(b)) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] bad_escape_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while ((b >= ESC_DIG0 && b <= ESC_DIG4) || is_reply_lead(b))
      b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic add_data();
    int p;
    p = $urandom_range(99);
    if (p < 60) begin
      stim_q.push_back(item_of(REQ_BYTE, plain_byte()));
    end else begin
      stim_q.push_back(item_of(REQ_BYTE, C_ESC));
      if (p < 90) stim_q.push_back(item_of(REQ_BYTE, 8'(ESC_DIG0 + $urandom_range(4))));
      else stim_q.push_back(item_of(REQ_BYTE, bad_escape_byte()));
    end
  endtask

  task automatic add_reply();
    if ($urandom_range(6) == 0) stim_q.push_back(item_of(REQ_BYTE, C_ESC));
    stim_q.push_back(item_of(REQ_BYTE, pick_lead()));
    add_data();
    if ($urandom_range(9) == 0) stim_q.push_back(item_of(REQ_TICK, 8'($urandom_range(255))));
    add_data();
  endtask

  task automatic queue_burst();
    int p;
    int n;
    p = $urandom_range(99);
    if (p < 20) begin
      n = ($urandom_range(49) == 0) ? PEND_MAX + 3 : $urandom_range(1, 3);
      repeat (n) stim_q.push_back(item_of(REQ_SENT, 8'($urandom_range(255))));
    end else if (p < 65) begin
      add_reply();
    end else if (p < 73) begin
      // reply cut short by a fresh lead
      stim_q.push_back(item_of(REQ_BYTE, pick_lead()));
      if ($urandom_range(1) == 1) add_data();
      if ($urandom_range(1) == 1) stim_q.push_back(item_of(REQ_BYTE, C_ESC));
      add_reply();
    end else if (p < 83) begin
      n = ($urandom_range(9) < 3) ? int'(tmo) + 2 : $urandom_range(1, 6);
      repeat (n) stim_q.push_back(item_of(REQ_TICK, 8'($urandom_range(255))));
    end else if (p < 93) begin
      repeat ($urandom_range(1, 4))
        stim_q.push_back(item_of(REQ_BYTE, 8'($urandom_range(255))));
    end else begin
      stim_q.push_back(item_of(REQ_NONE, 8'($urandom_range(255))));
    end
  endtask

  task automatic send_item(input in_item_t it, input logic known, input out_item_t known_res);
    out_item_t res;
    bit has;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    has = deframe_step(it, res);
    if (known) reply_q.push_back(known_res);
    else if (has) reply_q.push_back(res);
    items_in++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tmo = v;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_pct = 30;
        rx_pct <= 63;
      end
      1: begin
        send_pct = 63;
        rx_pct <= 30;
      end
      default: begin
        send_pct = 0;
        rx_pct <= 0;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", results_out, what, got, want);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (got.status < 5) st_seen[got.status]++;
    if (reply_q.size() == 0) begin
      report_mismatch("unexpected reply", 64'(got), 64'(0));
    end else begin
      want = reply_q.pop_front();
      if (got.lead_code != want.lead_code)
        report_mismatch("lead_code", 64'(got.lead_code), 64'(want.lead_code));
      if (got.data_first != want.data_first)
        report_mismatch("data_first", 64'(got.data_first), 64'(want.data_first));
      if (got.data_second != want.data_second)
        report_mismatch("data_second", 64'(got.data_second), 64'(want.data_second));
      if (got.status != want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
    end
    results_out++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) check_result(out_item_o);
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d replies outstanding",
               STALL_LIMIT, reply_q.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    dir_row_t dir_tab [25];
    int phase_items;
    logic [7:0] next_tmo;
    foreach (st_seen[i]) st_seen[i] = 0;
    dir_tab = '{
      dir_plain(REQ_BYTE, C_ACK),
      dir_plain(REQ_TICK, 8'h00),
      dir_plain(REQ_NONE, 8'hFF),
      dir_plain(REQ_SENT, 8'h00),
      dir_plain(REQ_BYTE, C_ESC),
      dir_plain(REQ_BYTE, 8'h00),
      dir_plain(REQ_BYTE, 8'hFF),
      dir_known(REQ_BYTE, 8'h41, 8'h00, 8'h00, 8'h00, ST_NOLEAD),
      dir_plain(REQ_SENT, 8'hFF),
      dir_plain(REQ_SENT, 8'h00),
      dir_plain(REQ_SENT, 8'h00),
      dir_plain(REQ_BYTE, C_ACK),
      dir_plain(REQ_BYTE, C_ESC),
      dir_plain(REQ_BYTE, ESC_DIG0),
      dir_known(REQ_BYTE, 8'hFF, C_ACK, C_ESC, 8'hFF, ST_OK),
      dir_plain(REQ_BYTE, C_NAK),
      dir_plain(REQ_BYTE, C_ESC),
      dir_plain(REQ_BYTE, 8'h35),
      dir_plain(REQ_BYTE, C_ESC),
      dir_known(REQ_BYTE, ESC_DIG4, 8'h00, 8'h00, 8'h00, ST_BADESC),
      dir_plain(REQ_BYTE, C_BEL),
      dir_plain(REQ_BYTE, C_ESC),
      dir_known(REQ_BYTE, C_ACK, 8'h00, 8'h00, 8'h00, ST_TRUNC),
      dir_plain(REQ_BYTE, 8'h00),
      dir_plain(REQ_BYTE, 8'h80)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0);
    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].known, dir_tab[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        drain_results();
        case (ph)
          1:       next_tmo = 8'd1;
          2:       next_tmo = 8'd255;
          3:       next_tmo = 8'd0;
          4: begin
            next_tmo = 8'($urandom_range(2, 40));
            mid_tmo = int'(next_tmo);
          end
          default: next_tmo = 8'd3;
        endcase
        write_timeout(next_tmo);
      end
      set_idling(ph / 2);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        queue_burst();
        while (stim_q.size() != 0) begin
          send_item(stim_q.pop_front(), 1'b0, '0);
          phase_items++;
          // long receiver stall while items keep coming
          if (ph == 4 && phase_items == 60) hold_go <= 1'b1;
        end
      end
    end

    drain_results();
    $display("Run covered %0d items and %0d replies over timeouts 31, 1, 255, 0, %0d and 3",
             items_in, results_out, mid_tmo);
    $display("Reply mix: ok %0d, bad escape %0d, truncated %0d, no lead %0d, timeout %0d",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
